// ----- src/fla_pkg.sv -----
`timescale 1ns / 1ps
// Package for the free-list slot allocator: sizes, status codes, slot word type.
// No dependencies.
package fla_pkg;

    localparam int POOL_SLOTS  = 256;
    localparam int SLOT_W      = $clog2(POOL_SLOTS);
    localparam int COUNT_W     = $clog2(POOL_SLOTS + 1);
    localparam int SEQ_W       = 64;
    localparam int SOCK_W      = 16;
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = SEQ_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNKS);

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_NOT_BUSY = 2'd2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic [SOCK_W-1:0] socket;
        logic              busy;
        logic              flag;
        logic [SEQ_W-1:0]  seq;
    } slot_word_t;

    localparam slot_word_t SLOT_RESET = '{socket: '0, busy: 1'b0, flag: 1'b1, seq: '0};

    function automatic logic [SLOT_W-1:0] ring_step(input logic [SLOT_W-1:0] ptr);
        ring_step = (ptr == SLOT_W'(POOL_SLOTS - 1)) ? '0 : ptr + 1'b1;
    endfunction

endpackage

// ----- src/fla_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/free_list_slot_allocator.sv -----
`timescale 1ns / 1ps
// Free-list slot allocator with per-slot generation counter.
// Uses fla_pkg and two fla_ram instances (free ring, slot table).
//
// Input channel (in_valid / in_stall): func 0 allocates the slot at the ring
// head and stores socket_id in it; func 1 releases slot_index to the ring tail.
// Output channel (out_valid / out_stall): one result transaction per request
// with status, slot index, validity flag, 64-bit sequence and free count.
// One request is processed at a time; in_stall is high while it is in flight.
// Allocate: ring read, slot read, sequence increment, write-back. Release:
// slot read, increment, write-back. An empty pool or an out-of-range
// release skips to write-back; so does an unallocated slot after its read.
// The sequence increment uses one shared 16-bit adder, one chunk per cycle.
// The result sits in an output register; a stalled result holds and the block
// completes the next request only once that register is free.
// Reset empties the output register and restores the pool: all slots free in
// index order, flags 1, sequences 0. No clearing pass is needed: per-slot
// touched bits and the ring fill mark stand in for the reset contents.
module free_list_slot_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  logic [7:0]       slot_index,
    input  logic [15:0]      socket_id,
    output logic             out_valid,
    input  logic             out_stall,
    output fla_pkg::status_t status,
    output logic [7:0]       granted_index,
    output logic             validity_bit,
    output logic [63:0]      sequence_res,
    output logic [8:0]       free_count
);
    import fla_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RING    = 3'd1;
    localparam logic [2:0] S_SLOT_RD = 3'd2;
    localparam logic [2:0] S_SLOT    = 3'd3;
    localparam logic [2:0] S_INC     = 3'd4;
    localparam logic [2:0] S_WB      = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic                   func_reg, func_next;
    logic [7:0]             idx_reg, idx_next;
    logic [SOCK_W-1:0]      sock_reg, sock_next;
    logic [SOCK_W-1:0]      rsock_reg, rsock_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    status_t                stat_reg, stat_next;
    logic                   flag_reg, flag_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic                   carry_reg, carry_next;
    logic                   ones_reg, ones_next;
    logic [CHUNK_CNT_W-1:0] cnt_reg, cnt_next;

    logic [SLOT_W-1:0]      head_reg, head_next;
    logic [SLOT_W-1:0]      tail_reg, tail_next;
    logic                   wrapped_reg, wrapped_next;
    logic [COUNT_W-1:0]     free_reg, free_next;
    logic [POOL_SLOTS-1:0]  touched_reg, touched_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [7:0]             out_index_reg, out_index_next;
    logic                   out_vbit_reg, out_vbit_next;
    logic [SEQ_W-1:0]       out_seq_reg, out_seq_next;
    logic [8:0]             out_free_reg, out_free_next;

    logic                   ring_we;
    logic [SLOT_W-1:0]      ring_rdata;
    logic                   slot_we;
    slot_word_t             slot_wdata;
    slot_word_t             slot_rdata;
    slot_word_t             slot_word;
    logic [CHUNK_W:0]       chunk_sum;
    logic [SEQ_W-1:0]       seq_fin;

    fla_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (slot_reg),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    fla_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(POOL_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_reg),
        .wdata (slot_wdata),
        .raddr (slot_reg),
        .rdata (slot_rdata)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_index = out_index_reg;
    assign validity_bit  = out_vbit_reg;
    assign sequence_res  = out_seq_reg;
    assign free_count    = out_free_reg;

    assign slot_word = touched_reg[slot_reg] ? slot_rdata : SLOT_RESET;
    assign chunk_sum = {1'b0, seq_reg[CHUNK_W-1:0]} + (CHUNK_W + 1)'(carry_reg);
    assign seq_fin   = ones_reg ? '0 : seq_reg;

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        sock_next       = sock_reg;
        rsock_next      = rsock_reg;
        slot_next       = slot_reg;
        stat_next       = stat_reg;
        flag_next       = flag_reg;
        seq_next        = seq_reg;
        carry_next      = carry_reg;
        ones_next       = ones_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        wrapped_next    = wrapped_reg;
        free_next       = free_reg;
        touched_next    = touched_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_vbit_next   = out_vbit_reg;
        out_seq_next    = out_seq_reg;
        out_free_next   = out_free_reg;
        ring_we         = 1'b0;
        slot_we         = 1'b0;
        slot_wdata      = SLOT_RESET;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    idx_next  = slot_index;
                    sock_next = socket_id;
                    stat_next = ST_OK;
                    if (func == FUNC_ALLOC)
                    begin
                        if (free_reg == '0)
                        begin
                            stat_next  = ST_EMPTY;
                            state_next = S_WB;
                        end
                        else
                        begin
                            state_next = S_RING;
                        end
                    end
                    else if ({24'd0, slot_index} >= 32'(POOL_SLOTS))
                    begin
                        stat_next  = ST_NOT_BUSY;
                        state_next = S_WB;
                    end
                    else
                    begin
                        slot_next  = SLOT_W'(slot_index);
                        state_next = S_SLOT_RD;
                    end
                end
            end

            S_RING:
            begin
                // entries at or past the tail were never written before the first wrap
                slot_next  = (wrapped_reg || (head_reg < tail_reg)) ? ring_rdata : head_reg;
                state_next = S_SLOT_RD;
            end

            S_SLOT_RD:
            begin
                state_next = S_SLOT;
            end

            S_SLOT:
            begin
                if (func_reg == FUNC_RELEASE && !slot_word.busy)
                begin
                    stat_next  = ST_NOT_BUSY;
                    state_next = S_WB;
                end
                else
                begin
                    rsock_next = slot_word.socket;
                    flag_next  = slot_word.flag;
                    seq_next   = slot_word.seq;
                    carry_next = 1'b1;
                    ones_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_INC;
                end
            end

            S_INC:
            begin
                seq_next   = {chunk_sum[CHUNK_W-1:0], seq_reg[SEQ_W-1:CHUNK_W]};
                carry_next = chunk_sum[CHUNK_W];
                ones_next  = ones_reg & (&chunk_sum[CHUNK_W-1:0]);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CHUNK_CNT_W'(CHUNKS - 1))
                begin
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_index_next  = '0;
                    out_vbit_next   = 1'b0;
                    out_seq_next    = '0;
                    out_free_next   = 9'(free_reg);
                    case (stat_reg)
                        ST_OK:
                        begin
                            slot_we                = 1'b1;
                            touched_next[slot_reg] = 1'b1;
                            out_index_next         = 8'(slot_reg);
                            out_seq_next           = seq_fin;
                            if (func_reg == FUNC_ALLOC)
                            begin
                                slot_wdata    = '{socket: sock_reg, busy: 1'b1,
                                                  flag: ~flag_reg, seq: seq_fin};
                                head_next     = ring_step(head_reg);
                                free_next     = free_reg - 1'b1;
                                out_vbit_next = ~flag_reg;
                            end
                            else
                            begin
                                slot_wdata    = '{socket: rsock_reg, busy: 1'b0,
                                                  flag: flag_reg, seq: seq_fin};
                                ring_we       = 1'b1;
                                tail_next     = ring_step(tail_reg);
                                free_next     = free_reg + 1'b1;
                                out_vbit_next = flag_reg;
                                if (tail_reg == SLOT_W'(POOL_SLOTS - 1))
                                begin
                                    wrapped_next = 1'b1;
                                end
                            end
                            out_free_next = 9'(free_next);
                        end
                        ST_EMPTY:
                        begin
                            out_index_next = '0;
                        end
                        default:
                        begin
                            out_index_next = idx_reg;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            wrapped_reg   <= 1'b0;
            free_reg      <= COUNT_W'(POOL_SLOTS);
            touched_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wrapped_reg   <= wrapped_next;
            free_reg      <= free_next;
            touched_reg   <= touched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        sock_reg       <= sock_next;
        rsock_reg      <= rsock_next;
        slot_reg       <= slot_next;
        stat_reg       <= stat_next;
        flag_reg       <= flag_next;
        seq_reg        <= seq_next;
        carry_reg      <= carry_next;
        ones_reg       <= ones_next;
        cnt_reg        <= cnt_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_vbit_reg   <= out_vbit_next;
        out_seq_reg    <= out_seq_next;
        out_free_reg   <= out_free_next;
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= COUNT_W'(POOL_SLOTS))
        else $error("free count above pool size");

    a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) |-> (free_reg == '0 || free_reg == COUNT_W'(POOL_SLOTS)))
        else $error("ring pointers disagree with free count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_EMPTY) |-> (out_free_reg == '0))
        else $error("empty status with free slots");

    a_seq_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_OK) |-> (out_seq_reg != '1))
        else $error("sequence reached all ones");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_seq_reg)))
        else $error("stalled result changed");

endmodule
